// ===== design/gas_sensor_breath_test_sequencer_unit_assert.svh =====
// Assertion macros shared by the breath test sequencer.
// Every assertion samples on clk_i and is disabled while rst_ni is low.
`ifndef GAS_SENSOR_BREATH_TEST_SEQUENCER_UNIT_ASSERT_SVH
`define GAS_SENSOR_BREATH_TEST_SEQUENCER_UNIT_ASSERT_SVH

// General property check.
`define GSBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define GSBT_ASSERT_NEVER(lbl, cond, msg) \
  `GSBT_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/gsbt_pkg.sv =====
package gsbt_pkg;

  // Width of the sensor converter reading that the sequencer uses.
  localparam int unsigned SampleBits = 10;
  // Four samples are summed, so the sum needs two more bits.
  localparam int unsigned SumBits    = SampleBits + 2;
  localparam int unsigned OffBits    = 10;
  localparam int unsigned WideBits   = (SampleBits > OffBits) ? SampleBits : OffBits;
  localparam int unsigned TimeBits   = 16;
  localparam int unsigned SpaceBits  = 14;
  // One extra bit so that a sample time beyond the counter range never matches.
  localparam int unsigned SchedBits  = TimeBits + 1;

  // Action codes of an input request.
  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActKill  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] CfgFirstSample  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgSampleSpace  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgWindowEnd    = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgHighOffset   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgMidOffset    = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_S0    = 4'd2,
    PH_S1    = 4'd3,
    PH_S2    = 4'd4,
    PH_S3    = 4'd5,
    PH_BLOW  = 4'd6,
    PH_END   = 4'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_WORKING = 2'd1,
    ST_DONE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LV_SOBER = 2'd0,
    LV_TIPSY = 2'd1,
    LV_DRUNK = 2'd2
  } level_e;

  typedef struct packed {
    logic [TimeBits-1:0]  first_sample_ms;
    logic [SpaceBits-1:0] sample_spacing_ms;
    logic [TimeBits-1:0]  window_end_ms;
    logic [OffBits-1:0]   high_offset;
    logic [OffBits-1:0]   mid_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] tick_ms;
    logic [9:0]  sample;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] level;
    logic       heater_on;
    logic [9:0] baseline;
  } out_t;

  typedef struct packed {
    phase_e                phase;
    logic [TimeBits-1:0]   elapsed_ms;
    logic [SumBits-1:0]    sample_sum;
    logic [SampleBits-1:0] baseline_level;
    logic [SampleBits-1:0] high_threshold;
    logic [SampleBits-1:0] mid_threshold;
    level_e                test_level;
    logic                  heater;
  } state_t;

  // Baseline minus offset, held at zero when the offset is the larger.
  function automatic logic [SampleBits-1:0] sat_sub(input logic [SampleBits-1:0] a,
                                                    input logic [OffBits-1:0] b);
    logic [WideBits-1:0] aw;
    logic [WideBits-1:0] bw;
    aw = WideBits'(a);
    bw = WideBits'(b);
    return (aw > bw) ? SampleBits'(aw - bw) : '0;
  endfunction

endpackage

// ===== design/gas_sensor_breath_test_sequencer_unit.sv =====
// A request accepted at a clock edge is held in the input register and then moves into
// the result register, which drives the outputs, once that register is empty or drains.
// Throughput: one request per cycle while the consumer keeps up; the step logic between
// the input and result registers updates the whole sequencer state combinationally.
// Reset (rst_ni low, asynchronous) empties both pipeline registers, puts the
// sequence in idle with heater off and level sober, and loads the timing defaults.
module gas_sensor_breath_test_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gsbt_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gsbt_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gsbt_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [15:0]                     cfg_data_i
);

  `include "gas_sensor_breath_test_sequencer_unit_assert.svh"

  gsbt_pkg::cfg_t   cfg;
  gsbt_pkg::state_t st_q;
  gsbt_pkg::state_t st_d;
  gsbt_pkg::in_t    in_q;
  gsbt_pkg::out_t   out_q;
  gsbt_pkg::out_t   result;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_take;

  // Configuration writes are always taken. The user must write only while the sequencer
  // has nothing in flight; the block itself does not enforce this and has no interlock.
  assign cfg_ready_o = 1'b1;

  gsbt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // A held request moves into the result register when that register is empty
  // or is being drained in this same cycle. The input register then frees up,
  // so a new request can be accepted every cycle while the consumer keeps up.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // The step logic sees the held request and the current sequencer state, and
  // produces the next state together with the result of this step.
  gsbt_step_logic u_step (
    .cfg_i    (cfg),
    .state_i  (st_q),
    .item_i   (in_q),
    .state_o  (st_d),
    .result_o (result)
  );

  // The sequencer state only moves when a step is committed to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase          <= gsbt_pkg::PH_IDLE;
      st_q.elapsed_ms     <= '0;
      st_q.sample_sum     <= '0;
      st_q.baseline_level <= '0;
      st_q.high_threshold <= '0;
      st_q.mid_threshold  <= '0;
      st_q.test_level     <= gsbt_pkg::LV_SOBER;
      st_q.heater         <= 1'b0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A start is resolved within its own step, so the start phase is never stored.
  `GSBT_ASSERT_NEVER(a_no_stored_start, st_q.phase == gsbt_pkg::PH_START,
                     "start phase stored")
  // Whenever the sequence rests in idle the heater must be off.
  `GSBT_ASSERT(a_idle_heater_off, st_q.phase == gsbt_pkg::PH_IDLE |-> !st_q.heater,
               "heater on in idle")
  // A drunk verdict ends the test: only the end phase or idle may follow it.
  `GSBT_ASSERT(a_drunk_ends,
               st_q.test_level == gsbt_pkg::LV_DRUNK |->
                 (st_q.phase == gsbt_pkg::PH_END || st_q.phase == gsbt_pkg::PH_IDLE),
               "drunk level while test runs")
  // A request held behind a stalled result must stay put until it can move on.
  `GSBT_ASSERT(a_hold_on_stall,
               in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q && $stable(in_q),
               "held request lost")

endmodule

// ===== design/gsbt_cfg_regs.sv =====
module gsbt_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [gsbt_pkg::CfgIdxBits-1:0]     wr_index_i,
  input  logic [15:0]                         wr_data_i,
  output gsbt_pkg::cfg_t                      cfg_o
);

  gsbt_pkg::cfg_t cfg_q;
  gsbt_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        gsbt_pkg::CfgFirstSample: begin
          cfg_d.first_sample_ms = wr_data_i[gsbt_pkg::TimeBits-1:0];
        end
        gsbt_pkg::CfgSampleSpace: begin
          cfg_d.sample_spacing_ms = wr_data_i[gsbt_pkg::SpaceBits-1:0];
        end
        gsbt_pkg::CfgWindowEnd: begin
          cfg_d.window_end_ms = wr_data_i[gsbt_pkg::TimeBits-1:0];
        end
        gsbt_pkg::CfgHighOffset: begin
          cfg_d.high_offset = wr_data_i[gsbt_pkg::OffBits-1:0];
        end
        gsbt_pkg::CfgMidOffset: begin
          cfg_d.mid_offset = wr_data_i[gsbt_pkg::OffBits-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_sample_ms   <= 16'd7000;
      cfg_q.sample_spacing_ms <= 14'd1000;
      cfg_q.window_end_ms     <= 16'd17000;
      cfg_q.high_offset       <= 10'd20;
      cfg_q.mid_offset        <= 10'd15;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/gsbt_step_logic.sv =====
module gsbt_step_logic (
  input  gsbt_pkg::cfg_t   cfg_i,
  input  gsbt_pkg::state_t state_i,
  input  gsbt_pkg::in_t    item_i,
  output gsbt_pkg::state_t state_o,
  output gsbt_pkg::out_t   result_o
);

  logic [gsbt_pkg::SampleBits-1:0] smp;
  logic [1:0]                      slot;
  logic [gsbt_pkg::SchedBits-1:0]  spacing;
  logic [gsbt_pkg::SchedBits-1:0]  sample_time;
  logic [gsbt_pkg::SumBits-1:0]    sum_new;
  logic [gsbt_pkg::SampleBits-1:0] base_new;
  gsbt_pkg::phase_e                ph;
  gsbt_pkg::status_e               status;
  gsbt_pkg::state_t                nxt;

  assign smp     = gsbt_pkg::SampleBits'(item_i.sample);
  // Slot number of the current baseline sample, valid in the sampling phases only.
  assign slot    = 2'(4'(state_i.phase) - 4'(gsbt_pkg::PH_S0));
  assign spacing = gsbt_pkg::SchedBits'(cfg_i.sample_spacing_ms);
  // first + slot * spacing, built from a shift and two adds.
  assign sample_time = gsbt_pkg::SchedBits'(cfg_i.first_sample_ms)
                     + (slot[0] ? spacing : '0)
                     + (slot[1] ? gsbt_pkg::SchedBits'(spacing << 1) : '0);
  assign sum_new  = (slot == 2'd0) ? gsbt_pkg::SumBits'(smp)
                                   : state_i.sample_sum + gsbt_pkg::SumBits'(smp);
  assign base_new = sum_new[gsbt_pkg::SumBits-1:2];

  always_comb begin
    nxt            = state_i;
    nxt.elapsed_ms = state_i.elapsed_ms + item_i.tick_ms;
    status         = gsbt_pkg::ST_IDLE;
    ph             = state_i.phase;
    if (item_i.action == gsbt_pkg::ActKill) begin
      nxt.heater = 1'b0;
      nxt.phase  = gsbt_pkg::PH_IDLE;
      status     = gsbt_pkg::ST_DONE;
    end else begin
      if (item_i.action == gsbt_pkg::ActStart) begin
        nxt.heater     = 1'b1;
        nxt.elapsed_ms = '0;
        nxt.test_level = gsbt_pkg::LV_SOBER;
        ph             = gsbt_pkg::PH_START;
      end
      case (ph)
        gsbt_pkg::PH_START: begin
          nxt.heater = 1'b1;
          nxt.phase  = gsbt_pkg::PH_S0;
          status     = gsbt_pkg::ST_WORKING;
        end
        gsbt_pkg::PH_S0, gsbt_pkg::PH_S1, gsbt_pkg::PH_S2, gsbt_pkg::PH_S3: begin
          status = gsbt_pkg::ST_WORKING;
          if (gsbt_pkg::SchedBits'(nxt.elapsed_ms) >= sample_time) begin
            nxt.sample_sum = sum_new;
            if (slot == 2'd3) begin
              nxt.baseline_level = base_new;
              nxt.high_threshold = gsbt_pkg::sat_sub(base_new, cfg_i.high_offset);
              nxt.mid_threshold  = gsbt_pkg::sat_sub(base_new, cfg_i.mid_offset);
              nxt.phase          = gsbt_pkg::PH_BLOW;
            end else begin
              nxt.phase = gsbt_pkg::phase_e'(4'(ph) + 4'd1);
            end
          end
        end
        gsbt_pkg::PH_BLOW: begin
          status = gsbt_pkg::ST_WORKING;
          if (nxt.elapsed_ms > cfg_i.window_end_ms) begin
            nxt.phase = gsbt_pkg::PH_END;
          end else if (smp < state_i.high_threshold &&
                       state_i.test_level != gsbt_pkg::LV_DRUNK) begin
            nxt.test_level = gsbt_pkg::LV_DRUNK;
            nxt.phase      = gsbt_pkg::PH_END;
          end else if (smp < state_i.mid_threshold &&
                       state_i.test_level == gsbt_pkg::LV_SOBER) begin
            nxt.test_level = gsbt_pkg::LV_TIPSY;
          end
        end
        gsbt_pkg::PH_END: begin
          nxt.heater = 1'b0;
          nxt.phase  = gsbt_pkg::PH_IDLE;
          status     = gsbt_pkg::ST_DONE;
        end
        default: begin
          nxt.phase = gsbt_pkg::PH_IDLE;
          status    = gsbt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign state_o            = nxt;
  assign result_o.status    = status;
  assign result_o.level     = nxt.test_level;
  assign result_o.heater_on = nxt.heater;
  assign result_o.baseline  = 10'(nxt.baseline_level);

endmodule
